FILE: rtl/lrpw_pkg.sv
// Shared types, constants and codes for the line raster pixel writer.
// No dependencies; every other file imports this package.
package lrpw_pkg;

  localparam int COORD_BITS = 16;
  localparam int SPAN_W     = COORD_BITS + 1;
  localparam int ERR_W      = COORD_BITS + 3;
  localparam int SCR_BITS   = 13;
  localparam int PITCH_BITS = 15;
  localparam int FMT_BITS   = 2;
  localparam int ADDR_W     = 28;
  localparam int DATA_W     = 32;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  // compare width: wider than both a coordinate and a screen size
  localparam int CMP_W = ((COORD_BITS > SCR_BITS) ? COORD_BITS : SCR_BITS) + 1;

  localparam logic [SCR_BITS-1:0]   WIDTH_RST  = SCR_BITS'(320);
  localparam logic [SCR_BITS-1:0]   HEIGHT_RST = SCR_BITS'(200);
  localparam logic [PITCH_BITS-1:0] PITCH_RST  = PITCH_BITS'(320);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef enum logic [FMT_BITS-1:0] {
    FMT_RGB332 = 2'd0,
    FMT_BGRA   = 2'd1,
    FMT_TEXT   = 2'd2,
    FMT_NONE   = 2'd3
  } fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 8'd0,
    CFG_HEIGHT = 8'd1,
    CFG_PITCH  = 8'd2,
    CFG_FORMAT = 8'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [SCR_BITS-1:0]   width;
    logic [SCR_BITS-1:0]   height;
    logic [PITCH_BITS-1:0] pitch;
    fmt_t                  fmt;
  } cfg_t;

  typedef struct packed {
    logic                         active;
    logic                         last;
    logic signed [COORD_BITS-1:0] cur_x;
    logic signed [COORD_BITS-1:0] cur_y;
    logic [DATA_W-1:0]            color;
  } pt_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         we;
    logic [ADDR_W-1:0]            addr;
    logic [DATA_W-1:0]            data;
    logic                         last;
  } pix_t;

endpackage

FILE: rtl/lrpw_cfg_regs.sv
// Configuration registers: screen size, row pitch and pixel format.
// Depends on lrpw_pkg.
module lrpw_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [lrpw_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [lrpw_pkg::CFG_DATA_W-1:0]  wr_data,
  output lrpw_pkg::cfg_t                   cfg
);
  import lrpw_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= WIDTH_RST;
      cfg_r.height <= HEIGHT_RST;
      cfg_r.pitch  <= PITCH_RST;
      cfg_r.fmt    <= FMT_RGB332;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_WIDTH:  cfg_r.width  <= wr_data[SCR_BITS-1:0];
        CFG_HEIGHT: cfg_r.height <= wr_data[SCR_BITS-1:0];
        CFG_PITCH:  cfg_r.pitch  <= wr_data[PITCH_BITS-1:0];
        CFG_FORMAT: cfg_r.fmt    <= fmt_t'(wr_data[FMT_BITS-1:0]);
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/lrpw_stepper.sv
// Bresenham line state: latches endpoints on load, advances one point per step.
// Depends on lrpw_pkg.
module lrpw_stepper (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  logic                                step,
  input  logic signed [lrpw_pkg::COORD_BITS-1:0] x_start,
  input  logic signed [lrpw_pkg::COORD_BITS-1:0] y_start,
  input  logic signed [lrpw_pkg::COORD_BITS-1:0] x_end,
  input  logic signed [lrpw_pkg::COORD_BITS-1:0] y_end,
  input  logic [lrpw_pkg::DATA_W-1:0]         color,
  output lrpw_pkg::pt_t                       pt
);
  import lrpw_pkg::*;

  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r, goal_x_r, goal_y_r;
  logic signed [COORD_BITS-1:0] cur_x_nxt, cur_y_nxt;
  logic [SPAN_W-1:0]            span_x_r, span_y_r;
  logic [SPAN_W-1:0]            ld_span_x, ld_span_y;
  logic                         dir_x_neg_r, dir_y_neg_r;
  logic signed [ERR_W-1:0]      err_r, err_nxt;
  logic                         active_r;
  logic [DATA_W-1:0]            color_r;
  logic signed [SPAN_W-1:0]     dx, dy;
  logic signed [ERR_W:0]        e2, neg_sy, pos_sx;
  logic                         last;

  // Absolute deltas of the new endpoints
  always_comb begin
    dx = SPAN_W'(x_end) - SPAN_W'(x_start);
    dy = SPAN_W'(y_end) - SPAN_W'(y_start);
    ld_span_x = dx[SPAN_W-1] ? SPAN_W'(-dx) : SPAN_W'(dx);
    ld_span_y = dy[SPAN_W-1] ? SPAN_W'(-dy) : SPAN_W'(dy);
  end

  assign last = (cur_x_r == goal_x_r) && (cur_y_r == goal_y_r);

  // One Bresenham step: compare doubled error against both spans
  always_comb begin
    e2     = {err_r, 1'b0};
    neg_sy = -$signed({2'b00, span_y_r});
    pos_sx = $signed({2'b00, span_x_r});
    err_nxt   = err_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (e2 > neg_sy) begin
      err_nxt   = err_nxt - $signed({2'b00, span_y_r});
      cur_x_nxt = dir_x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
    end
    if (e2 < pos_sx) begin
      err_nxt   = err_nxt + $signed({2'b00, span_x_r});
      cur_y_nxt = dir_y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      span_x_r    <= '0;
      span_y_r    <= '0;
      dir_x_neg_r <= 1'b0;
      dir_y_neg_r <= 1'b0;
      err_r       <= '0;
      active_r    <= 1'b0;
      color_r     <= '0;
    end else if (load) begin
      cur_x_r     <= x_start;
      cur_y_r     <= y_start;
      goal_x_r    <= x_end;
      goal_y_r    <= y_end;
      span_x_r    <= ld_span_x;
      span_y_r    <= ld_span_y;
      dir_x_neg_r <= !(x_start < x_end);
      dir_y_neg_r <= !(y_start < y_end);
      err_r       <= ERR_W'($signed({2'b00, ld_span_x})) - ERR_W'($signed({2'b00, ld_span_y}));
      active_r    <= 1'b1;
      color_r     <= color;
    end else if (step) begin
      if (last) begin
        active_r <= 1'b0;
      end else begin
        cur_x_r <= cur_x_nxt;
        cur_y_r <= cur_y_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  assign pt.active = active_r;
  assign pt.last   = last;
  assign pt.cur_x  = cur_x_r;
  assign pt.cur_y  = cur_y_r;
  assign pt.color  = color_r;

endmodule

FILE: rtl/lrpw_pixel_fmt.sv
// Pixel formatter: screen clip, byte address and pixel data for the current point.
// Depends on lrpw_pkg.
module lrpw_pixel_fmt (
  input  lrpw_pkg::pt_t  pt,
  input  lrpw_pkg::cfg_t cfg,
  output lrpw_pkg::pix_t pix
);
  import lrpw_pkg::*;

  logic [CMP_W-1:0]    px_u, py_u;
  logic                on_x, on_y, fmt_ok, we;
  logic [ADDR_W-1:0]   prod, sum;
  logic [CH_W-1:0]     r, g, b;

  always_comb begin
    px_u   = CMP_W'($unsigned(pt.cur_x));
    py_u   = CMP_W'($unsigned(pt.cur_y));
    on_x   = !pt.cur_x[COORD_BITS-1] && (px_u < CMP_W'(cfg.width));
    on_y   = !pt.cur_y[COORD_BITS-1] && (py_u < CMP_W'(cfg.height));
    fmt_ok = (cfg.fmt == FMT_RGB332) || (cfg.fmt == FMT_BGRA);
    we     = fmt_ok && on_x && on_y;

    // On screen both coordinates fit the screen-size width
    prod = ADDR_W'(py_u[SCR_BITS-1:0]) * ADDR_W'(cfg.pitch);
    sum  = prod + ADDR_W'(px_u[SCR_BITS-1:0]);

    b = pt.color[CH_W-1:0];
    g = pt.color[2*CH_W-1:CH_W];
    r = pt.color[3*CH_W-1:2*CH_W];

    pix.x    = pt.cur_x;
    pix.y    = pt.cur_y;
    pix.we   = we;
    pix.last = pt.last;
    pix.addr = '0;
    pix.data = '0;
    if (we) begin
      if (cfg.fmt == FMT_BGRA) begin
        pix.addr = {sum[ADDR_W-3:0], 2'b00};
        pix.data = pt.color;
      end else begin
        pix.addr = sum;
        pix.data = DATA_W'({r[7:5], g[7:5], b[7:6]});
      end
    end
  end

endmodule

FILE: rtl/line_raster_pixel_writer_top.sv
// Top level of the line raster pixel writer: handshake, output register.
// Depends on lrpw_pkg, lrpw_cfg_regs, lrpw_stepper and lrpw_pixel_fmt.
//
// Usage:
//   Input channel (in_valid/in_ready): a request with in_operation = load
//   latches two endpoints and an RGBA color and starts a line; it gives no
//   result. A step request emits the line's next pixel on the output
//   channel; a step with no line active is consumed and gives nothing.
//   Output channel (out_valid/out_ready): one request per pixel with its
//   coordinates, write enable, framebuffer byte address, pixel data and a
//   last flag on the end point. Address and data are zero when disabled.
//   Config channel (cfg_valid/cfg_ready): always ready; write only while
//   idle. Indexes 0..3 are width, height, pitch and format.
// Timing:
//   A pixel appears in the output register in the cycle after its step is
//   accepted. One request is accepted per cycle while the output is not
//   stalled; the stepper's Bresenham update is combinational, and the
//   formatter's multiply-add sits between that state and the output register.
// Reset: synchronous, active low; restores default registers and clears
//   any line. When the receiver stalls, the held pixel stays put and
//   in_ready drops until it is taken.
module line_raster_pixel_writer_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_operation,
  input  logic signed [lrpw_pkg::COORD_BITS-1:0] in_x_start,
  input  logic signed [lrpw_pkg::COORD_BITS-1:0] in_y_start,
  input  logic signed [lrpw_pkg::COORD_BITS-1:0] in_x_end,
  input  logic signed [lrpw_pkg::COORD_BITS-1:0] in_y_end,
  input  logic [lrpw_pkg::CH_W-1:0]              in_red,
  input  logic [lrpw_pkg::CH_W-1:0]              in_green,
  input  logic [lrpw_pkg::CH_W-1:0]              in_blue,
  input  logic [lrpw_pkg::CH_W-1:0]              in_alpha,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [lrpw_pkg::COORD_BITS-1:0] out_pixel_x,
  output logic signed [lrpw_pkg::COORD_BITS-1:0] out_pixel_y,
  output logic                                   out_write_enable,
  output logic [lrpw_pkg::ADDR_W-1:0]            out_byte_address,
  output logic [lrpw_pkg::DATA_W-1:0]            out_pixel_data,
  output logic                                   out_last_pixel,
  // configuration channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lrpw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lrpw_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import lrpw_pkg::*;

  cfg_t cfg;
  pt_t  pt;
  pix_t pix;
  pix_t out_r;
  logic out_valid_r;
  logic in_fire, load_fire, step_fire;

  // Accept whenever the output register is free or drains this cycle
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign load_fire = in_fire && (op_t'(in_operation) == OP_LOAD);
  // A step only counts when a line is in progress
  assign step_fire = in_fire && (op_t'(in_operation) == OP_STEP) && pt.active;

  assign cfg_ready = 1'b1;

  lrpw_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  lrpw_stepper u_stepper (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load_fire),
    .step    (step_fire),
    .x_start (in_x_start),
    .y_start (in_y_start),
    .x_end   (in_x_end),
    .y_end   (in_y_end),
    .color   ({in_alpha, in_red, in_green, in_blue}),
    .pt      (pt)
  );

  lrpw_pixel_fmt u_fmt (
    .pt  (pt),
    .cfg (cfg),
    .pix (pix)
  );

  // Output register: capture the pixel on a step, hold it while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_r <= pix;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = out_r.x;
  assign out_pixel_y      = out_r.y;
  assign out_write_enable = out_r.we;
  assign out_byte_address = out_r.addr;
  assign out_pixel_data   = out_r.data;
  assign out_last_pixel   = out_r.last;

  // A request that produces no pixel leaves the output empty
  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !step_fire) |=> !out_valid_r)
    else $error("output valid after a request with no result");

  // Emitting the end point closes the line
  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && pt.last) |=> !pt.active)
    else $error("line still active after its last pixel");

  // A load always opens a line
  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    load_fire |=> pt.active)
    else $error("line not active after load");

  // A disabled pixel carries zero address and data
  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.we) |-> (out_r.addr == '0 && out_r.data == '0))
    else $error("disabled pixel with nonzero address or data");

endmodule
